>>> rtl/growable_page_table_top_assert.svh
// Assertion macros for the growable page table top level.
// Needs clk and rst in the scope where a macro is used.
`ifndef GROWABLE_PAGE_TABLE_TOP_ASSERT_SVH
`define GROWABLE_PAGE_TABLE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define GPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpt: same-cycle check failed");
`define GPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpt: next-cycle check failed");
`else
`define GPT_ASSERT_NOW(lbl, ante, cons)
`define GPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/gpt_pkg.sv
// Shared types and codes for the growable page table.
// No dependencies.
`timescale 1ns / 1ps
package gpt_pkg;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_REMOVE    = 3'd2;
  localparam logic [2:0] OP_LOOKUP    = 3'd3;
  localparam logic [2:0] OP_TRANSLATE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXPANDED = 2'd1;
  localparam logic [1:0] ST_FAILED   = 2'd2;

  // width used for page compares (page, page + 1, virtual page, live size)
  localparam int XW = 17;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic take;  // accept request word, update table, start entry read
    logic load;  // move the finished result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  page_number;
    logic [15:0] frame_number;
    logic [2:0]  protection;
    logic [23:0] virtual_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  page_index;
    logic        entry_valid;
    logic [15:0] entry_frame;
    logic [2:0]  entry_protection;
    logic [28:0] physical_address;
    logic [7:0]  table_pages;
  } rsp_t;

endpackage

>>> rtl/gpt_req_if.sv
// Request channel: valid/ready plus the request word fields.
// No dependencies.
`timescale 1ns / 1ps
interface gpt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [9:0]  page_number;
  logic [15:0] frame_number;
  logic [2:0]  protection;
  logic [23:0] virtual_address;

  modport source (
    output valid, opcode, page_number, frame_number, protection, virtual_address,
    input  ready
  );
  modport sink (
    input  valid, opcode, page_number, frame_number, protection, virtual_address,
    output ready
  );
endinterface

>>> rtl/gpt_rsp_if.sv
// Response channel: valid/ready plus the result word fields.
// No dependencies.
`timescale 1ns / 1ps
interface gpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  page_index;
  logic        entry_valid;
  logic [15:0] entry_frame;
  logic [2:0]  entry_protection;
  logic [28:0] physical_address;
  logic [7:0]  table_pages;

  modport source (
    output valid, status, page_index, entry_valid, entry_frame, entry_protection,
           physical_address, table_pages,
    input  ready
  );
  modport sink (
    input  valid, status, page_index, entry_valid, entry_frame, entry_protection,
           physical_address, table_pages,
    output ready
  );
endinterface

>>> rtl/gpt_ctrl.sv
// Controller FSM: request handshake, result hand-off, output valid flag.
// Depends on gpt_pkg.
`timescale 1ns / 1ps
module gpt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output gpt_pkg::ctrl_cmd_t   cmd
);
  import gpt_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        // output register free or draining this cycle
        if (!out_valid || rsp_ready) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign rsp_valid = out_valid;

endmodule

>>> rtl/gpt_dp.sv
// Datapath: valid flops, entry memory, free search, growth unit, result register.
// Depends on gpt_pkg.
`timescale 1ns / 1ps
module gpt_dp #(
  parameter int MAX_ENTRIES = 128,
  parameter int PAGE_SHIFT  = 13,
  parameter int FRAME_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  gpt_pkg::ctrl_cmd_t  cmd,
  input  gpt_pkg::req_t       req,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  output gpt_pkg::rsp_t       rsp
);
  import gpt_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (LW > 8) ? LW : 8;
  localparam int GW = XW + LW;
  localparam int EW = FRAME_BITS + 3;
  localparam int PW = FRAME_BITS + PAGE_SHIFT;
  localparam int VW = 24 - PAGE_SHIFT;
  localparam logic [LW-1:0] INIT_LIVE = (MAX_ENTRIES < 8) ? LW'(MAX_ENTRIES) : LW'(8);

  logic [MAX_ENTRIES-1:0] vbits;
  logic [LW-1:0]          live;
  logic [EW-1:0]          mem [MAX_ENTRIES];
  logic [EW-1:0]          rd_entry;

  // held between accept and result load
  logic [1:0]            res_status;
  logic [6:0]            res_pidx;
  logic                  res_store;
  logic                  res_read;
  logic                  res_xlate;
  logic                  res_valid;
  logic [FRAME_BITS-1:0] res_frame;
  logic [2:0]            res_prot;
  logic [PAGE_SHIFT-1:0] res_off;

  // accept-cycle decode
  logic [XW-1:0]         page_x;
  logic [VW-1:0]         vp;
  logic [XW-1:0]         vp_x;
  logic [XW-1:0]         live_x;
  logic [XW-1:0]         need_x;
  logic                  can_grow;
  logic [GW-1:0]         grow_n;
  logic [AW-1:0]         ff_idx;
  logic                  ff_found;
  logic [AW-1:0]         p_addr;
  logic [1:0]            st_c;
  logic [6:0]            pidx_c;
  logic                  store_c;
  logic                  read_c;
  logic                  clear_c;
  logic                  xlate_c;
  logic [LW-1:0]         live_c;
  logic [LW-1:0]         cfg_live;
  logic [FRAME_BITS-1:0] frame_in;

  // result build
  logic [FRAME_BITS-1:0] ef;
  logic [2:0]            ep;
  logic                  ev;
  rsp_t                  rsp_c;

  assign page_x   = XW'(req.page_number);
  assign vp       = req.virtual_address[23:PAGE_SHIFT];
  assign vp_x     = XW'(vp);
  assign live_x   = XW'(live);
  assign frame_in = FRAME_BITS'(req.frame_number);

  // first free slot below the live size, lowest index wins
  always_comb begin
    ff_idx   = '0;
    ff_found = 1'b0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!vbits[i] && (LW'(i) < live)) begin
        ff_idx   = AW'(i);
        ff_found = 1'b1;
      end
    end
  end

  // growth: smallest live * 2^k (k >= 1) covering need, capped at the max
  always_comb begin
    logic [GW-1:0] cand;
    need_x   = (req.opcode == OP_INSERT) ? '0 : page_x + XW'(1);
    can_grow = (live < LW'(MAX_ENTRIES)) && (need_x <= XW'(MAX_ENTRIES));
    grow_n   = GW'(MAX_ENTRIES);
    for (int k = AW; k >= 1; k--) begin
      cand = GW'(live) << k;
      if (cand >= GW'(need_x)) grow_n = cand;
    end
    if (grow_n > GW'(MAX_ENTRIES)) grow_n = GW'(MAX_ENTRIES);
  end

  always_comb begin
    st_c    = ST_FAILED;
    pidx_c  = '0;
    p_addr  = '0;
    store_c = 1'b0;
    read_c  = 1'b0;
    clear_c = 1'b0;
    xlate_c = 1'b0;
    live_c  = live;
    case (req.opcode)
      OP_INSERT: begin
        if (ff_found) begin
          p_addr  = ff_idx;
          st_c    = ST_OK;
          store_c = 1'b1;
          pidx_c  = 7'(ff_idx);
        end else if (can_grow) begin
          p_addr  = AW'(live);
          st_c    = ST_EXPANDED;
          store_c = 1'b1;
          pidx_c  = 7'(AW'(live));
          live_c  = LW'(grow_n);
        end
      end
      OP_WRITE: begin
        p_addr = AW'(page_x);
        pidx_c = req.page_number[6:0];
        if (page_x < live_x) begin
          st_c    = ST_OK;
          store_c = 1'b1;
        end else if (can_grow) begin
          st_c    = ST_EXPANDED;
          store_c = 1'b1;
          live_c  = LW'(grow_n);
        end
      end
      OP_REMOVE, OP_LOOKUP: begin
        p_addr = AW'(page_x);
        pidx_c = req.page_number[6:0];
        if (page_x < live_x) begin
          st_c    = ST_OK;
          read_c  = 1'b1;
          clear_c = (req.opcode == OP_REMOVE);
        end
      end
      OP_TRANSLATE: begin
        p_addr = AW'(vp_x);
        pidx_c = 7'(vp_x);
        if (vp_x < live_x) begin
          st_c    = ST_OK;
          read_c  = 1'b1;
          xlate_c = 1'b1;
        end
      end
      default: st_c = ST_FAILED;
    endcase
  end

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_live = LW'(1);
    end else if (CW'(cfg_wr_data) > CW'(MAX_ENTRIES)) begin
      cfg_live = LW'(MAX_ENTRIES);
    end else begin
      cfg_live = LW'(cfg_wr_data);
    end
  end

  // slots past the live size are never valid, so growth needs no clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
      live  <= INIT_LIVE;
    end else if (cfg_wr_en) begin
      vbits <= '0;
      live  <= cfg_live;
    end else if (cmd.take) begin
      if (store_c) vbits[p_addr] <= 1'b1;
      if (clear_c) vbits[p_addr] <= 1'b0;
      live <= live_c;
    end
  end

  // entry memory; an invalid slot reads as zero through its valid bit
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (store_c) mem[p_addr] <= {frame_in, req.protection};
      rd_entry <= mem[p_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_status <= st_c;
      res_pidx   <= pidx_c;
      res_store  <= store_c;
      res_read   <= read_c;
      res_xlate  <= xlate_c;
      res_valid  <= store_c | (vbits[p_addr] & ~clear_c);
      res_frame  <= frame_in;
      res_prot   <= req.protection;
      res_off    <= req.virtual_address[PAGE_SHIFT-1:0];
    end
  end

  always_comb begin
    ev = (res_store | res_read) & res_valid;
    if (res_store) begin
      ef = res_frame;
      ep = res_prot;
    end else if (res_read && res_valid) begin
      ef = rd_entry[EW-1:3];
      ep = rd_entry[2:0];
    end else begin
      ef = '0;
      ep = '0;
    end
    rsp_c.status           = res_status;
    rsp_c.page_index       = res_pidx;
    rsp_c.entry_valid      = ev;
    rsp_c.entry_frame      = 16'(ef);
    rsp_c.entry_protection = ep;
    rsp_c.physical_address = res_xlate ?
                             29'((PW'(ef) << PAGE_SHIFT) | PW'(res_off)) : '0;
    rsp_c.table_pages      = 8'(live);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) rsp <= rsp_c;
  end

endmodule

>>> rtl/growable_page_table_top.sv
// Growable page table: one request in flight; accept/table-update in S_IDLE, then
// the registered entry-memory read feeds the result register, loaded in S_RESP
// once the output register is free or draining; then the next request is taken.
// Synchronous reset: table empty, live size 8 (capped at MAX_ENTRIES).
// A write on cfg_wr_en also empties the table and sets the live size.
`timescale 1ns / 1ps
`include "growable_page_table_top_assert.svh"
module growable_page_table_top #(
  parameter int MAX_ENTRIES = 128,
  parameter int PAGE_SHIFT  = 13,
  parameter int FRAME_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  gpt_req_if.sink     req,
  gpt_rsp_if.source   rsp,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import gpt_pkg::*;

  ctrl_cmd_t cmd;
  req_t      req_word;
  rsp_t      rsp_word;

  // request word fields gathered for the datapath
  assign req_word.opcode          = req.opcode;
  assign req_word.page_number     = req.page_number;
  assign req_word.frame_number    = req.frame_number;
  assign req_word.protection      = req.protection;
  assign req_word.virtual_address = req.virtual_address;

  // controller owns the handshakes; the datapath never sees valid/ready
  gpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // table state, free search, growth and result register
  gpt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req         (req_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rsp         (rsp_word)
  );

  // result word fields out to the response channel
  assign rsp.status           = rsp_word.status;
  assign rsp.page_index       = rsp_word.page_index;
  assign rsp.entry_valid      = rsp_word.entry_valid;
  assign rsp.entry_frame      = rsp_word.entry_frame;
  assign rsp.entry_protection = rsp_word.entry_protection;
  assign rsp.physical_address = rsp_word.physical_address;
  assign rsp.table_pages      = rsp_word.table_pages;

  // one request in flight: no accept in the cycle after an accept
  `GPT_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
  // with an empty output register the result shows with no stall in S_RESP
  `GPT_ASSERT_NOW(a_result_latency, req.valid && req.ready && !rsp.valid, ##2 rsp.valid)
  // status code is always a defined one
  `GPT_ASSERT_NOW(a_status_code, rsp.valid,
    rsp.status == ST_OK || rsp.status == ST_EXPANDED || rsp.status == ST_FAILED)

endmodule
